>>> rtl/core/first_fit_block_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit block allocator core
// Immediate-implication and next-cycle-implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define FFBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants and types of the first-fit block allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffba_pkg;

    localparam int POOL_WORDS_DEF    = 1024;
    localparam int TABLE_ENTRIES_DEF = 64;

    typedef enum logic [1:0] {
        ST_GRANTED = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_FULL    = 2'd2,
        ST_ZERO    = 2'd3
    } t_status;

endpackage

>>> rtl/core/ffba_if.sv
// ----------------------------------------------------------------------------
// ffba_req_if / ffba_rsp_if
// Valid/ready channels for allocation requests and their results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ffba_req_if #(
    parameter int SIZE_W = 11
);
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] request_size;

    modport source (output valid, output request_size, input ready);
    modport sink   (input valid, input request_size, output ready);
endinterface

interface ffba_rsp_if import ffba_pkg::*; #(
    parameter int ADDR_W = 10,
    parameter int CNT_W  = 7
);
    logic              valid;
    logic              ready;
    t_status           status;
    logic [ADDR_W-1:0] granted_start;
    logic [CNT_W-1:0]  blocks_in_use;

    modport source (output valid, output status, output granted_start,
                    output blocks_in_use, input ready);
    modport sink   (input valid, input status, input granted_start,
                    input blocks_in_use, output ready);
endinterface

>>> rtl/core/ffba_table.sv
// ----------------------------------------------------------------------------
// ffba_table
// Block table memory: one write and one registered read per cycle. Entry 0
// reads as the whole free pool until it is first written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffba_table import ffba_pkg::*; #(
    parameter int POOL_WORDS    = POOL_WORDS_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]  i_waddr,
    input  logic [$clog2(POOL_WORDS)-1:0]     i_wstart,
    input  logic [$clog2(POOL_WORDS)-1:0]     i_wlast,
    input  logic                              i_wused,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]  i_raddr,
    output logic [$clog2(POOL_WORDS)-1:0]     o_rstart,
    output logic [$clog2(POOL_WORDS)-1:0]     o_rlast,
    output logic                              o_rused
);

    localparam int ADDR_W = $clog2(POOL_WORDS);
    localparam int WORD_W = 2 * ADDR_W + 1;
    localparam logic [ADDR_W-1:0] POOL_LAST = ADDR_W'(POOL_WORDS - 1);

    logic [WORD_W-1:0] r_mem [TABLE_ENTRIES];
    logic [WORD_W-1:0] r_rdata;
    logic              r_rd_zero;
    logic              r_e0_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wstart, i_wlast, i_wused};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata   <= r_mem[i_raddr];
        r_rd_zero <= (i_raddr == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0_valid <= 1'b0;
        end else if (i_we && i_waddr == '0) begin
            r_e0_valid <= 1'b1;
        end
    end

    always_comb begin
        if (r_rd_zero && !r_e0_valid) begin
            o_rstart = '0;
            o_rlast  = POOL_LAST;
            o_rused  = 1'b0;
        end else begin
            o_rstart = r_rdata[WORD_W-1 -: ADDR_W];
            o_rlast  = r_rdata[ADDR_W:1];
            o_rused  = r_rdata[0];
        end
    end

endmodule

>>> rtl/core/first_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit allocator over an address-ordered block table held in memory.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request_size per transaction; o_rsp returns one result
//   (status, granted_start, blocks_in_use) per request, in order.
//   A request is taken only while the sequencer is idle; a finished result
//   sits in the output register, so the next request is taken while it waits.
//   A zero size skips the table and goes straight to the result. Otherwise the
//   table is scanned one entry per cycle through the single read port up to the
//   first fitting entry (or all blocks_in_use entries on a miss); a split then
//   moves each later entry up by one, makes 2 insert writes, and then loads the
//   result.
//   Reset leaves one free block covering the whole pool and a count of one;
//   entry 0 reads as that block until first written, so no clearing pass runs.
//   A stalled receiver holds the result in the output register; a finished
//   request then waits in its last state until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "first_fit_block_allocator_core_assert.svh"

module first_fit_block_allocator_core import ffba_pkg::*; #(
    parameter int POOL_WORDS    = POOL_WORDS_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ffba_req_if.sink  i_req,
    ffba_rsp_if.source o_rsp
);

    localparam int ADDR_W = $clog2(POOL_WORDS);
    localparam int SIZE_W = ADDR_W + 1;
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_INS_HI,
        S_INS_LO,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [SIZE_W-1:0] r_req;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_src;
    logic [IDX_W-1:0]  r_hit;
    logic [ADDR_W-1:0] r_hit_start;
    logic [ADDR_W-1:0] r_hit_last;
    logic [CNT_W-1:0]  r_count;
    t_status           r_status;
    logic [ADDR_W-1:0] r_grant;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [ADDR_W-1:0] r_out_start;
    logic [CNT_W-1:0]  r_out_count;

    logic              tbl_we;
    logic [IDX_W-1:0]  tbl_waddr;
    logic [ADDR_W-1:0] tbl_wstart;
    logic [ADDR_W-1:0] tbl_wlast;
    logic              tbl_wused;
    logic [IDX_W-1:0]  tbl_raddr;
    logic [ADDR_W-1:0] rd_start;
    logic [ADDR_W-1:0] rd_last;
    logic              rd_used;

    logic [CNT_W-1:0]  cnt_m1;
    logic [IDX_W-1:0]  last_idx;
    logic [SIZE_W-1:0] rd_size;
    logic              fit;
    logic              exact;
    logic              full;
    logic [SIZE_W-1:0] split_start;
    logic              out_free;

    ffba_table #(
        .POOL_WORDS    (POOL_WORDS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (tbl_we),
        .i_waddr  (tbl_waddr),
        .i_wstart (tbl_wstart),
        .i_wlast  (tbl_wlast),
        .i_wused  (tbl_wused),
        .i_raddr  (tbl_raddr),
        .o_rstart (rd_start),
        .o_rlast  (rd_last),
        .o_rused  (rd_used)
    );

    assign cnt_m1      = r_count - CNT_W'(1);
    assign last_idx    = cnt_m1[IDX_W-1:0];
    assign rd_size     = {1'b0, rd_last} - {1'b0, rd_start} + SIZE_W'(1);
    assign fit         = !rd_used && (rd_last >= rd_start) && (rd_size >= r_req);
    assign exact       = (rd_size == r_req);
    assign full        = (r_count >= CNT_W'(TABLE_ENTRIES));
    assign split_start = {1'b0, r_hit_start} + r_req;
    assign out_free    = !r_out_valid || o_rsp.ready;

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.granted_start = r_out_start;
    assign o_rsp.blocks_in_use = r_out_count;

    // table port control
    always_comb begin
        tbl_we     = 1'b0;
        tbl_waddr  = r_idx;
        tbl_wstart = rd_start;
        tbl_wlast  = rd_last;
        tbl_wused  = 1'b1;
        tbl_raddr  = r_idx + IDX_W'(1);
        unique case (r_state)
            S_IDLE: begin
                tbl_raddr = '0;
            end
            S_SCAN: begin
                if (fit && exact) begin
                    tbl_we = 1'b1;
                end else if (fit && !full) begin
                    tbl_raddr = last_idx;
                end
            end
            S_SHIFT: begin
                tbl_we    = 1'b1;
                tbl_waddr = r_src + IDX_W'(1);
                tbl_wused = rd_used;
                tbl_raddr = r_src - IDX_W'(1);
            end
            S_INS_HI: begin
                tbl_we     = 1'b1;
                tbl_waddr  = r_hit + IDX_W'(1);
                tbl_wstart = split_start[ADDR_W-1:0];
                tbl_wlast  = r_hit_last;
                tbl_wused  = 1'b0;
            end
            S_INS_LO: begin
                tbl_we     = 1'b1;
                tbl_waddr  = r_hit;
                tbl_wstart = r_hit_start;
                tbl_wlast  = ADDR_W'(split_start - SIZE_W'(1));
                tbl_wused  = 1'b1;
            end
            S_DONE: begin
                tbl_raddr = '0;
            end
            default: begin
                tbl_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= CNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (o_rsp.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req <= i_req.request_size;
                        r_idx <= '0;
                        if (i_req.request_size == '0) begin
                            r_status <= ST_ZERO;
                            r_grant  <= '0;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + IDX_W'(1);
                    priority if (fit && exact) begin
                        r_status <= ST_GRANTED;
                        r_grant  <= rd_start;
                        r_state  <= S_DONE;
                    end else if (fit && full) begin
                        r_status <= ST_FULL;
                        r_grant  <= '0;
                        r_state  <= S_DONE;
                    end else if (fit) begin
                        r_hit       <= r_idx;
                        r_hit_start <= rd_start;
                        r_hit_last  <= rd_last;
                        r_src       <= last_idx;
                        r_state     <= (r_idx == last_idx) ? S_INS_HI : S_SHIFT;
                    end else if (r_idx == last_idx) begin
                        r_status <= ST_NOFIT;
                        r_grant  <= '0;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SHIFT: begin
                    r_src <= r_src - IDX_W'(1);
                    if (r_src == r_hit + IDX_W'(1)) begin
                        r_state <= S_INS_HI;
                    end
                end
                S_INS_HI: begin
                    r_state <= S_INS_LO;
                end
                S_INS_LO: begin
                    r_count  <= r_count + CNT_W'(1);
                    r_status <= ST_GRANTED;
                    r_grant  <= r_hit_start;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_start  <= r_grant;
                        r_out_count  <= r_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `FFBA_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1,
        (r_count != '0) && (r_count <= CNT_W'(TABLE_ENTRIES)),
        "block count out of range")
    `FFBA_ASSERT_NEXT(a_count_only_on_insert, i_clk, i_rst_n, r_state != S_INS_LO,
        r_count == $past(r_count), "block count changed outside insert")
    `FFBA_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_req.valid && i_req.ready,
        r_state != S_IDLE, "accepted request did not start")
    `FFBA_ASSERT_NOW(a_refused_start_zero, i_clk, i_rst_n,
        o_rsp.valid && (o_rsp.status != ST_GRANTED), o_rsp.granted_start == '0,
        "refused request carries a start address")
    `FFBA_ASSERT_NOW(a_shift_above_hit, i_clk, i_rst_n, r_state == S_SHIFT,
        r_src > r_hit, "shift source at or below the split entry")

endmodule
